FILE: rtl/core/ncsv_pkg.sv
// Shared types and constants for the nested-frame CSV record parser.
package ncsv_pkg;

    localparam int RECORD_CAPACITY = 32;
    localparam int LEN_W           = $clog2(RECORD_CAPACITY + 1);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int FIELD_COUNT     = 4;
    localparam int FIELD_W         = $clog2(FIELD_COUNT);
    localparam int CNT_W           = 3;
    localparam int VAL_W           = 16;

    localparam logic [7:0] OPEN_MARK  = 8'h23;
    localparam logic [7:0] CLOSE_MARK = 8'h40;
    localparam logic [7:0] SEP_MARK   = 8'h2C;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NINE_CHAR  = 8'h39;

    localparam logic signed [3:0] DEPTH_MAX     = 4'sd7;
    localparam logic signed [3:0] DEPTH_MIN     = -4'sd8;
    localparam logic signed [3:0] COLLECT_DEPTH = 4'sd2;

    // One queued operation: a collected byte, or the end of a record.
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } t_op;

endpackage

FILE: rtl/core/ncsv_front.sv
// Front end: tracks nesting depth and record fill, classifies each byte.
module ncsv_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output ncsv_pkg::t_op    o_op
);
    import ncsv_pkg::*;

    logic signed [3:0] r_depth, n_depth;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              accept;
    logic              collect;
    logic              emit;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    always_comb begin
        n_depth = r_depth;
        n_len   = r_len;
        collect = 1'b0;
        emit    = 1'b0;
        if (i_rx_byte == OPEN_MARK) begin
            if (r_depth < DEPTH_MAX) n_depth = r_depth + 4'sd1;
        end else if (i_rx_byte == CLOSE_MARK) begin
            if (r_depth > DEPTH_MIN) n_depth = r_depth - 4'sd1;
        end else if (r_depth == COLLECT_DEPTH && r_len < LEN_W'(RECORD_CAPACITY)) begin
            collect = 1'b1;
            n_len   = r_len + LEN_W'(1);
        end
        // close the record when the depth falls back to zero
        if (n_depth == 4'sd0 && n_len != '0) begin
            emit  = 1'b1;
            n_len = '0;
        end
    end

    assign o_push    = accept && (collect || emit);
    assign o_op.emit = emit;
    assign o_op.data = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= 4'sd0;
            r_len   <= '0;
        end else if (accept) begin
            r_depth <= n_depth;
            r_len   <= n_len;
        end
    end

endmodule

FILE: rtl/core/ncsv_queue.sv
// Short FIFO of operations between the front end and the parser.
module ncsv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ncsv_pkg::t_op    i_op,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output ncsv_pkg::t_op    o_op
);
    import ncsv_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (do_pop) r_rd <= bump(r_rd);
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/ncsv_back.sv
// Back end: streaming %d,%d,%d,%d parser with a registered result stage.
module ncsv_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  ncsv_pkg::t_op                  i_q_op,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_holder_value,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_first_slot_value,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_second_slot_value,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_third_slot_value,
    output logic [ncsv_pkg::CNT_W-1:0]     o_fields_converted
);
    import ncsv_pkg::*;

    typedef enum logic [1:0] {P_LEAD, P_SIGN, P_DIGIT, P_DONE} t_pstate;

    t_pstate            r_pst, n_pst;
    logic [FIELD_W-1:0] r_fld, n_fld;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic               r_neg, n_neg;
    logic [VAL_W-1:0]   r_val [FIELD_COUNT];
    logic [VAL_W-1:0]   sacc;
    logic [VAL_W-1:0]   acc10;
    logic [VAL_W-1:0]   dig;
    logic               store;
    logic               out_free;
    logic               take;
    logic [7:0]         b;
    logic               is_ws, is_dig, is_sign;
    logic [VAL_W-1:0]   res_val [FIELD_COUNT];
    logic [CNT_W-1:0]   res_cnt;

    assign b        = i_q_op.data;
    assign is_ws    = (b == SPACE_CHAR) || (b >= TAB_CHAR && b <= CR_CHAR);
    assign is_dig   = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
    assign is_sign  = (b == PLUS_CHAR) || (b == MINUS_CHAR);
    assign dig      = VAL_W'(b - ZERO_CHAR);
    assign acc10    = (r_acc << 3) + (r_acc << 1);
    assign sacc     = r_neg ? (VAL_W'(0) - r_acc) : r_acc;

    assign out_free = !o_valid || !i_stall;
    assign o_pop    = i_q_valid && (!i_q_op.emit || out_free);
    assign take     = o_pop;

    // next parser state for a collected byte
    always_comb begin
        n_pst = r_pst;
        n_fld = r_fld;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_neg = r_neg;
        store = 1'b0;
        case (r_pst)
            P_LEAD: begin
                if (is_ws) begin
                    n_pst = P_LEAD;
                end else if (is_sign) begin
                    n_neg = b == MINUS_CHAR;
                    n_pst = P_SIGN;
                end else if (is_dig) begin
                    n_acc = dig;
                    n_pst = P_DIGIT;
                end else begin
                    n_pst = P_DONE;
                end
            end
            P_SIGN: begin
                if (is_dig) begin
                    n_acc = dig;
                    n_pst = P_DIGIT;
                end else begin
                    n_pst = P_DONE;
                end
            end
            P_DIGIT: begin
                if (is_dig) begin
                    n_acc = acc10 + dig;
                end else begin
                    store = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                    n_acc = '0;
                    n_neg = 1'b0;
                    if (b == SEP_MARK && r_fld != FIELD_W'(FIELD_COUNT - 1)) begin
                        n_fld = r_fld + FIELD_W'(1);
                        n_pst = P_LEAD;
                    end else begin
                        n_pst = P_DONE;
                    end
                end
            end
            default: n_pst = P_DONE;
        endcase
    end

    // a field still in its digits at the end of the record counts as converted
    always_comb begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
            res_val[i] = (r_pst == P_DIGIT && r_fld == FIELD_W'(i)) ? sacc : r_val[i];
        end
        res_cnt = r_cnt + ((r_pst == P_DIGIT) ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pst <= P_LEAD;
            r_fld <= '0;
            r_cnt <= '0;
            r_acc <= '0;
            r_neg <= 1'b0;
            for (int i = 0; i < FIELD_COUNT; i++) r_val[i] <= '0;
            o_valid <= 1'b0;
        end else begin
            if (take && i_q_op.emit) begin
                r_pst <= P_LEAD;
                r_fld <= '0;
                r_cnt <= '0;
                r_acc <= '0;
                r_neg <= 1'b0;
                for (int i = 0; i < FIELD_COUNT; i++) r_val[i] <= '0;
            end else if (take) begin
                r_pst <= n_pst;
                r_fld <= n_fld;
                r_cnt <= n_cnt;
                r_acc <= n_acc;
                r_neg <= n_neg;
                if (store) r_val[r_fld] <= sacc;
            end
            if (take && i_q_op.emit) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_op.emit) begin
            o_holder_value      <= res_val[0];
            o_first_slot_value  <= res_val[1];
            o_second_slot_value <= res_val[2];
            o_third_slot_value  <= res_val[3];
            o_fields_converted  <= res_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fields_converted <= CNT_W'(FIELD_COUNT))
        else $error("converted count out of range");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fields_converted == '0) |->
        (o_holder_value == '0 && o_first_slot_value == '0 &&
         o_second_slot_value == '0 && o_third_slot_value == '0))
        else $error("unconverted fields not zero");

    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fields_converted < CNT_W'(FIELD_COUNT)) |->
        o_third_slot_value == '0)
        else $error("fourth field set without conversion");

    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && i_q_valid && i_q_op.emit) |-> !o_pop)
        else $error("result overwritten while stalled");

endmodule

FILE: rtl/core/nested_frame_csv_record_parser.sv
// Top level of the nested-frame CSV record parser.
//
// Input channel: i_valid / o_stall carry one received byte on i_rx_byte;
// a byte is taken at each edge where i_valid is high and o_stall is low.
// '#' raises and '@' lowers the nesting depth; other bytes at depth 2 go
// into the current record (up to 32 bytes, more are dropped).
// Output channel: o_valid / i_stall carry one result when the depth comes
// back to zero with a non-empty record: four 16-bit signed values and the
// count of fields converted (0..4), scanf "%d,%d,%d,%d" style.
// Throughput: one byte per cycle while o_stall is low; the record is parsed
// on the fly, one byte per cycle in the parser, never buffered whole.
// The end-of-record entry passes through the queue and then the registered
// result stage; entries still queued ahead of it are popped first.
// A four-entry queue parts the depth tracker from the parser; while the
// receiver stalls a held result, collected bytes still flow until the next
// record close reaches the parser, then the queue fills and o_stall rises.
// Reset (synchronous, active low) clears depth, record length, parser
// state, the queue and o_valid.
module nested_frame_csv_record_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_holder_value,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_first_slot_value,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_second_slot_value,
    output logic signed [ncsv_pkg::VAL_W-1:0] o_third_slot_value,
    output logic [ncsv_pkg::CNT_W-1:0]        o_fields_converted
);
    import ncsv_pkg::*;

    logic push, q_full, q_valid, pop;
    t_op  push_op, q_op;

    ncsv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_op      (push_op)
    );

    ncsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    ncsv_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_op              (q_op),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_holder_value      (o_holder_value),
        .o_first_slot_value  (o_first_slot_value),
        .o_second_slot_value (o_second_slot_value),
        .o_third_slot_value  (o_third_slot_value),
        .o_fields_converted  (o_fields_converted)
    );

endmodule

FILE: bench/tb_nested_frame_csv_record_parser.sv
// Self-checking testbench for the nested-frame CSV record parser.
module tb_nested_frame_csv_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ncsv_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [VAL_W-1:0] holder;
        logic [VAL_W-1:0] first_slot;
        logic [VAL_W-1:0] second_slot;
        logic [VAL_W-1:0] third_slot;
        logic [CNT_W-1:0] count;
    } t_record_fields;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic i_valid   = 1'b0;
    logic i_stall   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic o_stall;
    logic o_valid;
    logic signed [VAL_W-1:0] o_holder_value;
    logic signed [VAL_W-1:0] o_first_slot_value;
    logic signed [VAL_W-1:0] o_second_slot_value;
    logic signed [VAL_W-1:0] o_third_slot_value;
    logic [CNT_W-1:0] o_fields_converted;

    // Shadow copy of the parser state
    int         nest_level;
    logic [7:0] rec_bytes [RECORD_CAPACITY];
    int         rec_len;

    t_record_fields parsed_q[$];

    int  items_sent     = 0;
    int  records_parsed = 0;
    int  records_seen   = 0;
    int  mismatches     = 0;
    int  long_holds     = 0;
    int  hold_req       = 0;
    bit  send_burst     = 1'b0;
    bit  sink_burst     = 1'b0;

    nested_frame_csv_record_parser u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_holder_value      (o_holder_value),
        .o_first_slot_value  (o_first_slot_value),
        .o_second_slot_value (o_second_slot_value),
        .o_third_slot_value  (o_third_slot_value),
        .o_fields_converted  (o_fields_converted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR);
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= ZERO_CHAR && c <= NINE_CHAR;
    endfunction

    // scanf "%d,%d,%d,%d" over the collected record
    function automatic t_record_fields parse_fields();
        t_record_fields   r;
        logic [VAL_W-1:0] vals [FIELD_COUNT];
        logic [VAL_W-1:0] acc;
        logic             neg;
        int               pos;
        int               cnt;
        pos = 0;
        cnt = 0;
        for (int f = 0; f < FIELD_COUNT; f++) vals[f] = '0;
        for (int f = 0; f < FIELD_COUNT; f++) begin
            neg = 1'b0;
            acc = '0;
            if (f > 0) begin
                if (pos < rec_len && rec_bytes[pos] == SEP_MARK) pos++;
                else break;
            end
            while (pos < rec_len && is_blank(rec_bytes[pos])) pos++;
            if (pos < rec_len && (rec_bytes[pos] == PLUS_CHAR || rec_bytes[pos] == MINUS_CHAR)) begin
                neg = rec_bytes[pos] == MINUS_CHAR;
                pos++;
            end
            if (pos >= rec_len || !is_numeral(rec_bytes[pos])) break;
            while (pos < rec_len && is_numeral(rec_bytes[pos])) begin
                acc = acc * 16'd10 + {8'h00, rec_bytes[pos] - ZERO_CHAR};
                pos++;
            end
            if (neg) acc = -acc;
            vals[f] = acc;
            cnt++;
        end
        r.holder      = vals[0];
        r.first_slot  = vals[1];
        r.second_slot = vals[2];
        r.third_slot  = vals[3];
        r.count       = CNT_W'(cnt);
        return r;
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        if (b == OPEN_MARK) begin
            if (nest_level < DEPTH_MAX) nest_level++;
        end else if (b == CLOSE_MARK) begin
            if (nest_level > DEPTH_MIN) nest_level--;
        end else if (nest_level == COLLECT_DEPTH) begin
            if (rec_len < RECORD_CAPACITY) begin
                rec_bytes[rec_len] = b;
                rec_len++;
            end
        end
        if (nest_level == 0 && rec_len > 0) begin
            parsed_q.push_back(parse_fields());
            records_parsed++;
            rec_len = 0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        track_byte(b);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_record(input string body);
        send_byte(OPEN_MARK);
        send_byte(OPEN_MARK);
        send_text(body);
        send_byte(CLOSE_MARK);
        send_byte(CLOSE_MARK);
    endtask

    // Bring the depth back to zero after noise
    task automatic realign_depth();
        while (nest_level > 0) send_byte(CLOSE_MARK);
        while (nest_level < 0) send_byte(OPEN_MARK);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? SPACE_CHAR : 8'(TAB_CHAR + r - 1);
    endfunction

    function automatic logic [7:0] pick_junk();
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == OPEN_MARK || r == CLOSE_MARK);
        return r;
    endfunction

    task automatic send_number_field();
        int r;
        int n;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_byte(pick_blank());
        r = $urandom_range(0, 5);
        if (r == 0) send_byte(PLUS_CHAR);
        else if (r == 1) send_byte(MINUS_CHAR);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
        if ($urandom_range(0, 24) == 0) n = 0;
        repeat (n) send_byte(8'(ZERO_CHAR + $urandom_range(0, 9)));
    endtask

    task automatic send_random_record();
        int kind;
        int nf;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            realign_depth();
        end else if (kind == 1) begin
            send_byte(OPEN_MARK);
            send_byte(OPEN_MARK);
            repeat ($urandom_range(0, 12)) send_byte(pick_junk());
            realign_depth();
        end else begin
            send_byte(OPEN_MARK);
            if ($urandom_range(0, 7) == 0) send_byte(pick_junk());
            send_byte(OPEN_MARK);
            nf = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : FIELD_COUNT;
            for (int f = 0; f < nf; f++) begin
                if (f > 0) begin
                    if ($urandom_range(0, 19) == 0) send_byte(pick_junk());
                    else send_byte(SEP_MARK);
                end
                send_number_field();
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(OPEN_MARK);
                    repeat ($urandom_range(1, 3)) send_byte(pick_junk());
                    send_byte(CLOSE_MARK);
                end
            end
            send_byte(CLOSE_MARK);
            send_byte(CLOSE_MARK);
        end
        if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
    endtask

    task automatic test_field_extremes();
        send_record("0,0,0,0");
        send_record("32767,-32768,+1,-1");
        send_record("65535,65536,99999,-65535");
        send_record(" \0111,\012-2,\013+3,\014\0154");
    endtask

    task automatic test_parse_mismatch();
        send_record("1 ,2,3,4");
        send_record("-,5,6,7");
        send_record("1,2,+,4");
        send_record("   ");
        send_record("1,2,3,4,5");
        send_record("12x;8");
        // zero byte and all-ones byte are collected and stop the parse
        send_byte(OPEN_MARK);
        send_byte(OPEN_MARK);
        send_text("1");
        send_byte(8'h00);
        send_text(",2");
        send_byte(CLOSE_MARK);
        send_byte(CLOSE_MARK);
        send_byte(OPEN_MARK);
        send_byte(OPEN_MARK);
        send_text("5,");
        send_byte(8'hFF);
        send_byte(CLOSE_MARK);
        send_byte(CLOSE_MARK);
        // empty record: no result
        send_record("");
    endtask

    task automatic test_depth_saturation();
        send_byte(OPEN_MARK);
        send_byte(OPEN_MARK);
        send_text("3");
        repeat (6) send_byte(OPEN_MARK);
        repeat (16) send_byte(CLOSE_MARK);
        repeat (8) send_byte(OPEN_MARK);
        // bytes at depth 1 and 3 are ignored
        send_byte(OPEN_MARK);
        send_text("5");
        send_byte(OPEN_MARK);
        send_text("1");
        send_byte(OPEN_MARK);
        send_text("6");
        send_byte(CLOSE_MARK);
        send_text("2");
        send_byte(CLOSE_MARK);
        send_text("9");
        send_byte(CLOSE_MARK);
    endtask

    task automatic test_record_capacity();
        send_byte(OPEN_MARK);
        send_byte(OPEN_MARK);
        repeat (RECORD_CAPACITY + 8) send_byte(8'(ZERO_CHAR + $urandom_range(0, 9)));
        send_byte(CLOSE_MARK);
        send_byte(CLOSE_MARK);
        // the last field falls past the end of the record and is dropped
        send_byte(OPEN_MARK);
        send_byte(OPEN_MARK);
        send_text("1,2,3,");
        repeat (RECORD_CAPACITY - 6) send_byte(SPACE_CHAR);
        send_text("4");
        send_byte(CLOSE_MARK);
        send_byte(CLOSE_MARK);
    endtask

    task automatic test_backpressure();
        hold_req   = LONG_HOLD;
        send_burst = 1'b1;
        repeat (12) send_record($sformatf("%0d,-%0d,7,8", $urandom_range(0, 999),
                                          $urandom_range(0, 999)));
        send_burst = 1'b0;
    endtask

    task automatic test_random_records();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) send_random_record();
    endtask

    task automatic check_result();
        t_record_fields want;
        records_seen++;
        if (parsed_q.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("unexpected result: %0d %0d %0d %0d count %0d", o_holder_value,
                         o_first_slot_value, o_second_slot_value, o_third_slot_value,
                         o_fields_converted);
            mismatches++;
        end else begin
            want = parsed_q.pop_front();
            if (o_holder_value !== want.holder || o_first_slot_value !== want.first_slot ||
                o_second_slot_value !== want.second_slot ||
                o_third_slot_value !== want.third_slot || o_fields_converted !== want.count) begin
                if (mismatches < MAX_REPORTS)
                    $display("mismatch on result %0d: exp %0d %0d %0d %0d count %0d, got %0d %0d %0d %0d count %0d",
                             records_seen, $signed(want.holder), $signed(want.first_slot),
                             $signed(want.second_slot), $signed(want.third_slot), want.count,
                             o_holder_value, o_first_slot_value, o_second_slot_value,
                             o_third_slot_value, o_fields_converted);
                mismatches++;
            end
        end
    endtask

    // Result side: random stall per item, long hold on request
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req > 0) begin
                gap      = hold_req;
                hold_req = 0;
                long_holds++;
            end else begin
                if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
                gap = sink_burst ? 0 : $urandom_range(0, 14);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            check_result();
        end
    end

    // Abort when neither channel moves for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout: %0d results still outstanding", parsed_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        nest_level = 0;
        rec_len    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_parse_mismatch();
        test_depth_saturation();
        test_record_capacity();
        test_backpressure();
        test_random_records();
        i_valid <= 1'b0;
        while (parsed_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d bytes, expected %0d records, checked %0d (%0d mismatches), %0d long holds",
                 items_sent, records_parsed, records_seen, mismatches, long_holds);
        $display("covered field extremes, parse mismatches, depth saturation, full records");
        if (mismatches == 0 && records_seen == records_parsed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
